// ----- rtl/perceptron_delta_rule_trainer_macros.svh -----
// Assertion macros for the perceptron delta-rule trainer.
// Included by the top level; relies on i_clk and i_rst_n in the including scope.
`ifndef PERCEPTRON_DELTA_RULE_TRAINER_MACROS_SVH
`define PERCEPTRON_DELTA_RULE_TRAINER_MACROS_SVH

// same-cycle implication, disabled in reset
`define PDRT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pdrt assertion failed");

// next-cycle implication, disabled in reset
`define PDRT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pdrt assertion failed");

`endif

// ----- rtl/pdrt_pkg.sv -----
// Shared types, constants and saturation helpers for the perceptron trainer.
// No dependencies; used by pdrt_cell and perceptron_delta_rule_trainer.
package pdrt_pkg;

    localparam int NUM_FEATURES_DEF = 8;
    localparam int MAX_FEATURES     = 8;

    localparam int W_FEAT   = 16;
    localparam int W_WGT    = 32;
    localparam int W_LR     = 16;
    localparam int W_PROD   = W_WGT + W_FEAT;
    localparam int W_LE     = W_LR + 1 + W_WGT;
    localparam int W_DPROD  = W_LE + W_FEAT;
    localparam int W_WIDE   = 40;
    localparam int SHIFT_SUM = 12;
    localparam int SHIFT_UPD = 28;
    localparam int SHIFT_DES = 4;
    localparam int W_CFG    = 32;
    localparam int W_CFG_IDX = 1;

    typedef logic signed [W_FEAT-1:0]  t_feat;
    typedef logic signed [W_WGT-1:0]   t_weight;
    typedef logic        [W_LR-1:0]    t_lr;
    typedef logic signed [W_PROD-1:0]  t_prod;
    typedef logic signed [W_LE-1:0]    t_le;
    typedef logic signed [W_DPROD-1:0] t_dprod;
    typedef logic signed [W_WIDE-1:0]  t_wide;
    typedef logic signed [W_DPROD-SHIFT_UPD-1:0] t_delta;

    localparam t_weight S32_MAX = 32'sh7FFF_FFFF;
    localparam t_weight S32_MIN = 32'sh8000_0000;

    localparam t_lr     LR_RESET  = 16'd6554;
    localparam t_weight THR_RESET = 32'sd32768;

    localparam logic [1:0] KIND_INFER = 2'd0;
    localparam logic [1:0] KIND_TRAIN = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    localparam logic [W_CFG_IDX-1:0] REG_LEARNING_RATE = 1'd0;
    localparam logic [W_CFG_IDX-1:0] REG_THRESHOLD     = 1'd1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_CHAIN,
        ST_SUM,
        ST_ERR,
        ST_LE,
        ST_DMUL,
        ST_UPD,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic load_feat;
        logic calc_prod;
        logic calc_delta;
        logic write_weight;
        logic clear_weight;
    } t_cell_ctl;

    function automatic logic ovf32(input t_wide v);
        return (v > t_wide'(S32_MAX)) || (v < t_wide'(S32_MIN));
    endfunction

    function automatic t_weight sat32(input t_wide v);
        t_weight r;
        if (v > t_wide'(S32_MAX)) begin
            r = S32_MAX;
        end else if (v < t_wide'(S32_MIN)) begin
            r = S32_MIN;
        end else begin
            r = t_weight'(v);
        end
        return r;
    endfunction

endpackage

// ----- rtl/perceptron_delta_rule_trainer.sv -----
// Delta-rule (LMS) perceptron trainer. One item is taken at a time: after the
// input beat the block takes no new item until this one has gone through every
// step; its final step waits while an earlier result is held on output stall.
// The steps follow the row of weight cells: each cell forms weight times
// feature, the partial sum ripples one cell per cycle down the row, then sum,
// error, rate-times-error, per-cell delta and the weight write or clear are
// each registered in a state of their own. A finished result sits in an
// output register, so the input side can take the next beat while it waits.
// Depends on pdrt_pkg, pdrt_cell and perceptron_delta_rule_trainer_macros.svh.
`include "perceptron_delta_rule_trainer_macros.svh"

module perceptron_delta_rule_trainer #(
    parameter int NUM_FEATURES = pdrt_pkg::NUM_FEATURES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [pdrt_pkg::W_CFG_IDX-1:0]     i_cfg_index,
    input  logic [pdrt_pkg::W_CFG-1:0]         i_cfg_data,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [1:0]                         i_kind,
    input  pdrt_pkg::t_feat                    i_feature_0,
    input  pdrt_pkg::t_feat                    i_feature_1,
    input  pdrt_pkg::t_feat                    i_feature_2,
    input  pdrt_pkg::t_feat                    i_feature_3,
    input  pdrt_pkg::t_feat                    i_feature_4,
    input  pdrt_pkg::t_feat                    i_feature_5,
    input  pdrt_pkg::t_feat                    i_feature_6,
    input  pdrt_pkg::t_feat                    i_feature_7,
    input  pdrt_pkg::t_feat                    i_desired,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic                               o_class_bit,
    output pdrt_pkg::t_weight                  o_weighted_sum,
    output pdrt_pkg::t_weight                  o_error_value,
    output logic                               o_saturated
);

    localparam int ACC_W = pdrt_pkg::W_PROD + $clog2(NUM_FEATURES);
    localparam int CNT_W = $clog2(NUM_FEATURES + 1);

    pdrt_pkg::t_state           r_state;
    pdrt_pkg::t_state           n_state;
    logic [CNT_W-1:0]           r_cnt;
    pdrt_pkg::t_lr              r_lr;
    pdrt_pkg::t_weight          r_threshold;
    logic [1:0]                 r_kind;
    pdrt_pkg::t_feat            r_desired;
    pdrt_pkg::t_weight          r_sum;
    pdrt_pkg::t_weight          r_err;
    pdrt_pkg::t_le              r_le;
    logic                       r_class;
    logic                       r_clip;
    logic                       r_out_valid;
    logic                       r_out_class;
    pdrt_pkg::t_weight          r_out_sum;
    pdrt_pkg::t_weight          r_out_err;
    logic                       r_out_sat;

    pdrt_pkg::t_cell_ctl        cell_ctl;
    logic                       out_load;
    pdrt_pkg::t_feat            feat_in [pdrt_pkg::MAX_FEATURES];
    logic signed [ACC_W-1:0]    psum [NUM_FEATURES+1];
    logic [NUM_FEATURES-1:0]    cell_clip;
    pdrt_pkg::t_wide            sum_wide;
    pdrt_pkg::t_wide            err_wide;
    pdrt_pkg::t_le              n_le;

    assign feat_in[0] = i_feature_0;
    assign feat_in[1] = i_feature_1;
    assign feat_in[2] = i_feature_2;
    assign feat_in[3] = i_feature_3;
    assign feat_in[4] = i_feature_4;
    assign feat_in[5] = i_feature_5;
    assign feat_in[6] = i_feature_6;
    assign feat_in[7] = i_feature_7;

    assign psum[0] = '0;

    for (genvar g = 0; g < NUM_FEATURES; g++) begin : g_cell
        pdrt_cell #(
            .ACC_W(ACC_W)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (cell_ctl),
            .i_feature (feat_in[g]),
            .i_le      (r_le),
            .i_psum    (psum[g]),
            .o_psum    (psum[g+1]),
            .o_clip    (cell_clip[g])
        );
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pdrt_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_state = pdrt_pkg::ST_MUL;
                end
            end
            pdrt_pkg::ST_MUL:   n_state = pdrt_pkg::ST_CHAIN;
            pdrt_pkg::ST_CHAIN: begin
                if (r_cnt == CNT_W'(NUM_FEATURES - 1)) begin
                    n_state = pdrt_pkg::ST_SUM;
                end
            end
            pdrt_pkg::ST_SUM:   n_state = pdrt_pkg::ST_ERR;
            pdrt_pkg::ST_ERR:   n_state = pdrt_pkg::ST_LE;
            pdrt_pkg::ST_LE:    n_state = pdrt_pkg::ST_DMUL;
            pdrt_pkg::ST_DMUL:  n_state = pdrt_pkg::ST_UPD;
            pdrt_pkg::ST_UPD:   n_state = pdrt_pkg::ST_OUT;
            pdrt_pkg::ST_OUT: begin
                if (!r_out_valid || !i_stall) begin
                    n_state = pdrt_pkg::ST_IDLE;
                end
            end
            default:            n_state = pdrt_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_stall                = (r_state != pdrt_pkg::ST_IDLE);
        cell_ctl.load_feat     = (r_state == pdrt_pkg::ST_IDLE) && i_valid;
        cell_ctl.calc_prod     = (r_state == pdrt_pkg::ST_MUL);
        cell_ctl.calc_delta    = (r_state == pdrt_pkg::ST_DMUL);
        cell_ctl.write_weight  = (r_state == pdrt_pkg::ST_UPD) &&
                                 (r_kind == pdrt_pkg::KIND_TRAIN);
        cell_ctl.clear_weight  = (r_state == pdrt_pkg::ST_UPD) &&
                                 (r_kind == pdrt_pkg::KIND_CLEAR);
        out_load               = (r_state == pdrt_pkg::ST_OUT) &&
                                 (!r_out_valid || !i_stall);
    end

    always_comb begin
        sum_wide = pdrt_pkg::t_wide'(psum[NUM_FEATURES] >>> pdrt_pkg::SHIFT_SUM);
        err_wide = (pdrt_pkg::t_wide'(r_desired) <<< pdrt_pkg::SHIFT_DES) -
                   pdrt_pkg::t_wide'(r_sum);
        n_le     = pdrt_pkg::t_le'(signed'({1'b0, r_lr})) * pdrt_pkg::t_le'(r_err);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pdrt_pkg::ST_IDLE;
            r_cnt       <= '0;
            r_lr        <= pdrt_pkg::LR_RESET;
            r_threshold <= pdrt_pkg::THR_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == pdrt_pkg::ST_MUL) begin
                r_cnt <= '0;
            end else if (r_state == pdrt_pkg::ST_CHAIN) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    pdrt_pkg::REG_LEARNING_RATE: r_lr <= i_cfg_data[pdrt_pkg::W_LR-1:0];
                    pdrt_pkg::REG_THRESHOLD:     r_threshold <= i_cfg_data;
                    default: ;
                endcase
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (cell_ctl.load_feat) begin
            r_kind    <= i_kind;
            r_desired <= i_desired;
        end
        if (r_state == pdrt_pkg::ST_SUM) begin
            r_sum  <= pdrt_pkg::sat32(sum_wide);
            r_clip <= pdrt_pkg::ovf32(sum_wide);
        end else if (r_state == pdrt_pkg::ST_ERR) begin
            r_err   <= pdrt_pkg::sat32(err_wide);
            r_clip  <= r_clip | pdrt_pkg::ovf32(err_wide);
            r_class <= (r_sum > r_threshold);
        end else if (cell_ctl.write_weight) begin
            r_clip <= r_clip | (|cell_clip);
        end
        if (r_state == pdrt_pkg::ST_LE) begin
            r_le <= n_le;
        end
        if (out_load) begin
            r_out_class <= r_class;
            r_out_sum   <= r_sum;
            r_out_err   <= r_err;
            r_out_sat   <= r_clip;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_class_bit    = r_out_class;
    assign o_weighted_sum = r_out_sum;
    assign o_error_value  = r_out_err;
    assign o_saturated    = r_out_sat;

    `PDRT_ASSERT_NEXT(a_accept_starts, (r_state == pdrt_pkg::ST_IDLE) && i_valid, r_state == pdrt_pkg::ST_MUL)
    `PDRT_ASSERT_NEXT(a_out_only_from_done, !r_out_valid && (r_state != pdrt_pkg::ST_OUT), !r_out_valid)
    `PDRT_ASSERT_NOW(a_chain_count_bound, r_state == pdrt_pkg::ST_CHAIN, r_cnt < CNT_W'(NUM_FEATURES))

endmodule

// ----- rtl/pdrt_cell.sv -----
// One weight cell of the trainer row: holds a weight and a feature, forms its
// product into the rippling partial sum and applies its own weight update. Uses pdrt_pkg.
module pdrt_cell #(
    parameter int ACC_W = pdrt_pkg::W_PROD + 3
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  pdrt_pkg::t_cell_ctl     i_ctl,
    input  pdrt_pkg::t_feat         i_feature,
    input  pdrt_pkg::t_le           i_le,
    input  logic signed [ACC_W-1:0] i_psum,
    output logic signed [ACC_W-1:0] o_psum,
    output logic                    o_clip
);

    pdrt_pkg::t_weight          r_weight;
    pdrt_pkg::t_feat            r_feat;
    pdrt_pkg::t_prod            r_prod;
    pdrt_pkg::t_dprod           r_dprod;
    logic signed [ACC_W-1:0]    r_psum;

    pdrt_pkg::t_prod            n_prod;
    pdrt_pkg::t_dprod           n_dprod;
    logic signed [ACC_W-1:0]    n_psum;
    pdrt_pkg::t_delta           delta;
    pdrt_pkg::t_wide            wgt_wide;
    pdrt_pkg::t_weight          n_weight;

    always_comb begin
        n_prod   = pdrt_pkg::t_prod'(r_weight) * pdrt_pkg::t_prod'(r_feat);
        n_dprod  = pdrt_pkg::t_dprod'(i_le) * pdrt_pkg::t_dprod'(r_feat);
        n_psum   = i_psum + ACC_W'(r_prod);
        delta    = r_dprod[pdrt_pkg::W_DPROD-1:pdrt_pkg::SHIFT_UPD];
        wgt_wide = pdrt_pkg::t_wide'(r_weight) + pdrt_pkg::t_wide'(delta);
        n_weight = pdrt_pkg::sat32(wgt_wide);
        o_clip   = pdrt_pkg::ovf32(wgt_wide);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight <= '0;
        end else if (i_ctl.clear_weight) begin
            r_weight <= '0;
        end else if (i_ctl.write_weight) begin
            r_weight <= n_weight;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_feat) begin
            r_feat <= i_feature;
        end
        if (i_ctl.calc_prod) begin
            r_prod <= n_prod;
        end
        if (i_ctl.calc_delta) begin
            r_dprod <= n_dprod;
        end
        r_psum <= n_psum;
    end

    assign o_psum = r_psum;

endmodule
